/* rtl/dcc_fpd_pkg.sv */
// ----------------------------------------------------------------------------
// dcc_fpd_pkg
// Shared types and constants for the DCC function packet decoder: packet and
// result records, decoder state and command byte codes.
// ----------------------------------------------------------------------------
package dcc_fpd_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned ADDR_W  = 14;
  localparam int unsigned CADDR_W = 7;
  localparam int unsigned FUNC_W  = 29;
  localparam int unsigned CVN_W   = 9;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ADDR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_DECODER_ADDR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONSIST_ADDR = 2'd1;

  localparam logic [ADDR_W-1:0]  DECODER_ADDR_RST = 14'd3;
  localparam logic [CADDR_W-1:0] CONSIST_ADDR_RST = 7'd0;

  // Command byte codes
  localparam logic [BYTE_W-1:0] CMD_CV_MASK    = 8'b1111_1100;
  localparam logic [BYTE_W-1:0] CMD_CV_WRITE   = 8'b1110_1100;
  localparam logic [BYTE_W-1:0] CMD_SPEED_128  = 8'h3F;
  localparam logic [BYTE_W-1:0] CMD_GRP3_MASK  = 8'b1110_0000;
  localparam logic [BYTE_W-1:0] CMD_GRP_F0_F4  = 8'b1000_0000;
  localparam logic [BYTE_W-1:0] CMD_GRP4_MASK  = 8'b1111_0000;
  localparam logic [BYTE_W-1:0] CMD_GRP_F5_F8  = 8'b1011_0000;
  localparam logic [BYTE_W-1:0] CMD_GRP_F9_F12 = 8'b1010_0000;
  localparam logic [BYTE_W-1:0] CMD_F13_F20    = 8'b1101_1110;
  localparam logic [BYTE_W-1:0] CMD_F21_F28    = 8'b1101_1111;
  localparam logic [BYTE_W-1:0] LONG_ADDR_MASK = 8'b0011_1111;
  localparam logic [BYTE_W-1:0] SHORT_ADDR_MASK = 8'b0111_1111;

  // Decoder reset command: CV 8 (CV byte 7) written with 8
  localparam logic [BYTE_W-1:0] CV_BYTE_RESET  = 8'd7;
  localparam logic [BYTE_W-1:0] CV_VALUE_RESET = 8'd8;

  // Lengths for the speed and extended function packet checks
  localparam logic [LEN_W:0] LEN_SPEED_BASIC = 4'd2;
  localparam logic [LEN_W:0] LEN_SPEED_128   = 4'd3;
  localparam logic [LEN_W-1:0] LEN_EXT_FUNC  = 3'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_zero;
    logic [BYTE_W-1:0] byte_one;
    logic [BYTE_W-1:0] byte_two;
    logic [BYTE_W-1:0] byte_three;
    logic [BYTE_W-1:0] byte_four;
    logic [BYTE_W-1:0] byte_five;
    logic [LEN_W-1:0]  packet_length;
  } packet_t;

  typedef struct packed {
    logic [FUNC_W-1:0] function_bits;
    logic              forward;
    logic              changed;
    logic              cv_write_request;
    logic [CVN_W-1:0]  cv_number;
    logic [BYTE_W-1:0] cv_value;
    logic              reset_request;
  } result_t;

  typedef struct packed {
    logic [FUNC_W-1:0] functions;
    logic              forward;
    logic [BYTE_W-1:0] prev_err;
  } dec_state_t;

endpackage

/* rtl/dcc_fpd_decode.sv */
// ----------------------------------------------------------------------------
// dcc_fpd_decode
// Combinational packet decode: address match, CV write confirmation, speed
// direction and function group updates against the current decoder state.
// ----------------------------------------------------------------------------
module dcc_fpd_decode (
  input  dcc_fpd_pkg::packet_t    pkt,
  input  dcc_fpd_pkg::dec_state_t cur,
  input  logic [dcc_fpd_pkg::ADDR_W-1:0]  decoder_addr,
  input  logic [dcc_fpd_pkg::CADDR_W-1:0] consist_addr,
  output dcc_fpd_pkg::dec_state_t nxt_state,
  output dcc_fpd_pkg::result_t    res
);
  import dcc_fpd_pkg::*;

  logic              long_addr;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] cmd;
  logic [BYTE_W-1:0] arg1;
  logic [BYTE_W-1:0] arg2;
  logic [BYTE_W-1:0] err;
  logic [LEN_W:0]    len_ext;
  logic [LEN_W:0]    shift_ext;
  logic              match_dec;
  logic              match_any;
  logic              is_cv;
  logic              confirmed;
  logic              is_reset;
  logic [FUNC_W-1:0] new_func;
  logic              new_dir;

  // Address and command byte positions
  always_comb begin
    long_addr = pkt.byte_zero[7];
    if (long_addr) begin
      addr = {pkt.byte_zero[5:0] & LONG_ADDR_MASK[5:0], pkt.byte_one};
      cmd  = pkt.byte_two;
      arg1 = pkt.byte_three;
      arg2 = pkt.byte_four;
    end else begin
      addr = {7'd0, pkt.byte_zero[6:0] & SHORT_ADDR_MASK[6:0]};
      cmd  = pkt.byte_one;
      arg1 = pkt.byte_two;
      arg2 = pkt.byte_three;
    end
  end

  // Error byte: last byte of the packet, clamped to the first and sixth
  always_comb begin
    case (pkt.packet_length)
      3'd0, 3'd1: err = pkt.byte_zero;
      3'd2:       err = pkt.byte_one;
      3'd3:       err = pkt.byte_two;
      3'd4:       err = pkt.byte_three;
      3'd5:       err = pkt.byte_four;
      default:    err = pkt.byte_five;
    endcase
  end

  assign len_ext   = {1'b0, pkt.packet_length};
  assign shift_ext = {{LEN_W{1'b0}}, long_addr};
  assign match_dec = (addr == decoder_addr);
  assign match_any = match_dec || (addr == {{(ADDR_W-CADDR_W){1'b0}}, consist_addr});
  assign is_cv     = match_dec && ((cmd & CMD_CV_MASK) == CMD_CV_WRITE);
  // CV writes only count when repeated with the same error byte
  assign confirmed = is_cv && (err == cur.prev_err);
  assign is_reset  = (arg1 == CV_BYTE_RESET) && (arg2 == CV_VALUE_RESET);

  // Speed and function group updates
  always_comb begin
    new_func = cur.functions;
    new_dir  = cur.forward;
    if (!cmd[7]) begin
      if (cmd == CMD_SPEED_128 && len_ext == LEN_SPEED_128 + shift_ext) begin
        new_dir = arg1[7];
      end else if (len_ext == LEN_SPEED_BASIC + shift_ext) begin
        new_dir = cmd[5];
      end
    end else if ((cmd & CMD_GRP3_MASK) == CMD_GRP_F0_F4) begin
      new_func[0]   = cmd[4];
      new_func[4:1] = cmd[3:0];
    end else if ((cmd & CMD_GRP4_MASK) == CMD_GRP_F5_F8) begin
      new_func[8:5] = cmd[3:0];
    end else if ((cmd & CMD_GRP4_MASK) == CMD_GRP_F9_F12) begin
      new_func[12:9] = cmd[3:0];
    end else if (cmd == CMD_F13_F20) begin
      if (pkt.packet_length >= LEN_EXT_FUNC) begin
        new_func[20:13] = arg1;
      end
    end else if (cmd == CMD_F21_F28) begin
      if (pkt.packet_length >= LEN_EXT_FUNC) begin
        new_func[28:21] = arg1;
      end
    end
  end

  // Next state and result record
  always_comb begin
    nxt_state          = cur;
    nxt_state.prev_err = err;
    res                = '0;
    if (!is_cv && match_any) begin
      nxt_state.functions = new_func;
      nxt_state.forward   = new_dir;
      res.changed = (new_func != cur.functions) || (new_dir != cur.forward);
    end
    if (confirmed) begin
      if (is_reset) begin
        res.reset_request = 1'b1;
      end else begin
        res.cv_write_request = 1'b1;
        res.cv_number        = {1'b0, arg1} + 9'd1;
        res.cv_value         = arg2;
      end
    end
    res.function_bits = nxt_state.functions;
    res.forward       = nxt_state.forward;
  end

endmodule

/* rtl/dcc_fpd_regs.sv */
// ----------------------------------------------------------------------------
// dcc_fpd_regs
// Configuration registers and kept decoder state (functions, direction,
// previous error byte), updated once per decoded packet.
// ----------------------------------------------------------------------------
module dcc_fpd_regs (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [dcc_fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcc_fpd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                    upd,
  input  dcc_fpd_pkg::dec_state_t upd_state,
  output dcc_fpd_pkg::dec_state_t cur_state,
  output logic [dcc_fpd_pkg::ADDR_W-1:0]  decoder_addr,
  output logic [dcc_fpd_pkg::CADDR_W-1:0] consist_addr
);
  import dcc_fpd_pkg::*;

  dec_state_t         state_r;
  logic [ADDR_W-1:0]  dec_addr_r;
  logic [CADDR_W-1:0] con_addr_r;

  // Register writes and state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.functions <= '0;
      state_r.forward   <= 1'b1;
      state_r.prev_err  <= '0;
      dec_addr_r        <= DECODER_ADDR_RST;
      con_addr_r        <= CONSIST_ADDR_RST;
    end else begin
      if (upd) begin
        state_r <= upd_state;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECODER_ADDR: dec_addr_r <= cfg_data;
          CFG_CONSIST_ADDR: con_addr_r <= cfg_data[CADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cur_state    = state_r;
  assign decoder_addr = dec_addr_r;
  assign consist_addr = con_addr_r;

endmodule

/* rtl/dcc_function_packet_decoder_core.sv */
// ----------------------------------------------------------------------------
// dcc_function_packet_decoder_core
// DCC multifunction decoder packet handler, top level.
//
// Usage:
//   Input channel (in_valid / in_stall): one request carries a whole received
//   packet, six bytes and its length. Result channel (out_valid / out_stall):
//   one result per packet with the function vector, direction, change flag
//   and any confirmed CV write or decoder reset request.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 decoder address,
//   index 1 consist address; write only while the block is idle.
// Timing:
//   A packet is captured in an input register and decoded in one pass into
//   the result register. One packet per cycle is accepted while the result
//   side does not stall; the rate is set by the single decode stage that
//   reads and updates the kept state.
// Reset: rst_n clears both stages, functions off, direction forward,
//   previous error byte zero, decoder address 3, consist address 0.
// Stall: a stalled result holds; the input stage keeps accepting until it
//   holds a packet that cannot move on, then in_stall rises.
// ----------------------------------------------------------------------------
module dcc_function_packet_decoder_core (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_zero,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_one,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_two,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_three,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_four,
  input  logic [dcc_fpd_pkg::BYTE_W-1:0] in_byte_five,
  input  logic [dcc_fpd_pkg::LEN_W-1:0]  in_packet_length,
  output logic out_valid,
  input  logic out_stall,
  output logic [dcc_fpd_pkg::FUNC_W-1:0] out_function_bits,
  output logic                           out_forward,
  output logic                           out_changed,
  output logic                           out_cv_write_request,
  output logic [dcc_fpd_pkg::CVN_W-1:0]  out_cv_number,
  output logic [dcc_fpd_pkg::BYTE_W-1:0] out_cv_value,
  output logic                           out_reset_request,
  input  logic cfg_we,
  input  logic [dcc_fpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcc_fpd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dcc_fpd_pkg::*;

  logic        in_vld_r;
  logic        in_vld_nxt;
  packet_t     pkt_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  result_t     res_r;
  result_t     res_nxt;
  dec_state_t  cur_state;
  dec_state_t  upd_state;
  logic [ADDR_W-1:0]  decoder_addr;
  logic [CADDR_W-1:0] consist_addr;
  logic        advance;
  logic        in_take;

  // Handshake: input stage moves on when the result register is free or its result is taken
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (!in_stall) begin
      in_vld_nxt = in_valid;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      pkt_r.byte_zero     <= in_byte_zero;
      pkt_r.byte_one      <= in_byte_one;
      pkt_r.byte_two      <= in_byte_two;
      pkt_r.byte_three    <= in_byte_three;
      pkt_r.byte_four     <= in_byte_four;
      pkt_r.byte_five     <= in_byte_five;
      pkt_r.packet_length <= in_packet_length;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // Decode against current state
  dcc_fpd_decode u_decode (
    .pkt          (pkt_r),
    .cur          (cur_state),
    .decoder_addr (decoder_addr),
    .consist_addr (consist_addr),
    .nxt_state    (upd_state),
    .res          (res_nxt)
  );

  dcc_fpd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .upd          (advance),
    .upd_state    (upd_state),
    .cur_state    (cur_state),
    .decoder_addr (decoder_addr),
    .consist_addr (consist_addr)
  );

  assign out_valid            = out_vld_r;
  assign out_function_bits    = res_r.function_bits;
  assign out_forward          = res_r.forward;
  assign out_changed          = res_r.changed;
  assign out_cv_write_request = res_r.cv_write_request;
  assign out_cv_number        = res_r.cv_number;
  assign out_cv_value         = res_r.cv_value;
  assign out_reset_request    = res_r.reset_request;

endmodule

/* bench/dcc_function_packet_decoder_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcc_function_packet_decoder_core_test
// Self-checking bench for the DCC function packet decoder. Packets are driven
// from a backlog queue with random gaps; results are taken with random stalls
// and checked field by field against an in-bench decoder model that tracks
// the function vector, direction and last error byte. Several address
// settings are exercised, from a directed set of packets to long runs of
// random, mostly well-formed packets with repeated CV writes.
// ----------------------------------------------------------------------------
module dcc_function_packet_decoder_core_test;
  import dcc_fpd_pkg::*;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          RANDOM_PER_SET = 70;
  // Basic speed instruction, direction in bit 5
  localparam logic [7:0]  SPEED_BASIC    = 8'b0100_0000;
  localparam logic [7:0]  SPEED_DIR_FWD  = 8'b0010_0000;

  typedef struct {
    packet_t pkt;
    bit      drain;
  } backlog_entry_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [BYTE_W-1:0] in_byte_zero, in_byte_one, in_byte_two;
  logic [BYTE_W-1:0] in_byte_three, in_byte_four, in_byte_five;
  logic [LEN_W-1:0]  in_packet_length;
  logic out_valid;
  logic out_stall;
  logic [FUNC_W-1:0] out_function_bits;
  logic              out_forward;
  logic              out_changed;
  logic              out_cv_write_request;
  logic [CVN_W-1:0]  out_cv_number;
  logic [BYTE_W-1:0] out_cv_value;
  logic              out_reset_request;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dcc_function_packet_decoder_core uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_byte_zero         (in_byte_zero),
    .in_byte_one          (in_byte_one),
    .in_byte_two          (in_byte_two),
    .in_byte_three        (in_byte_three),
    .in_byte_four         (in_byte_four),
    .in_byte_five         (in_byte_five),
    .in_packet_length     (in_packet_length),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_function_bits    (out_function_bits),
    .out_forward          (out_forward),
    .out_changed          (out_changed),
    .out_cv_write_request (out_cv_write_request),
    .out_cv_number        (out_cv_number),
    .out_cv_value         (out_cv_value),
    .out_reset_request    (out_reset_request),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // Decoder model state and its copy of the address registers
  logic [FUNC_W-1:0]  loco_functions;
  logic               loco_forward;
  logic [BYTE_W-1:0]  last_err_byte;
  logic [ADDR_W-1:0]  own_address;
  logic [CADDR_W-1:0] consist_addr;

  backlog_entry_t packet_backlog[$];
  result_t        expected_results[$];

  bit in_taken;
  bit out_taken;
  bit idle_on;
  int send_gap;
  int recv_hold;
  int fail_count;
  int quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Decode one packet, advance the model state, return the expected result
  function automatic result_t decode_packet(packet_t p);
    logic [7:0]        pk [6];
    int                sh, len, eidx;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        cmd, nxt, nxt2, err;
    logic [FUNC_W-1:0] nf;
    logic              nd;
    result_t           r;
    pk[0] = p.byte_zero;
    pk[1] = p.byte_one;
    pk[2] = p.byte_two;
    pk[3] = p.byte_three;
    pk[4] = p.byte_four;
    pk[5] = p.byte_five;
    len = int'(p.packet_length);
    sh = p.byte_zero[7] ? 1 : 0;
    addr = sh ? {p.byte_zero[5:0], p.byte_one} : {7'd0, p.byte_zero[6:0]};
    cmd = pk[1 + sh];
    nxt = pk[2 + sh];
    nxt2 = pk[3 + sh];
    // error byte position saturates at both ends of the length field
    eidx = (len == 0) ? 0 : ((len > 6) ? 5 : len - 1);
    err = pk[eidx];
    r = '0;
    nf = loco_functions;
    nd = loco_forward;
    if (addr == own_address && (cmd & CMD_CV_MASK) == CMD_CV_WRITE) begin
      // CV write acts only on a repeated error byte
      if (err == last_err_byte) begin
        if (nxt == CV_BYTE_RESET && nxt2 == CV_VALUE_RESET) begin
          r.reset_request = 1'b1;
        end else begin
          r.cv_write_request = 1'b1;
          r.cv_number = {1'b0, nxt} + 9'd1;
          r.cv_value = nxt2;
        end
      end
    end else if (addr == own_address || addr == {7'd0, consist_addr}) begin
      if (!cmd[7]) begin
        // speed: direction only on an exact length
        if (cmd == CMD_SPEED_128 && len == 3 + sh) nd = nxt[7];
        else if (len == 2 + sh) nd = cmd[5];
      end else if ((cmd & CMD_GRP3_MASK) == CMD_GRP_F0_F4) begin
        nf[0] = cmd[4];
        nf[4:1] = cmd[3:0];
      end else if ((cmd & CMD_GRP4_MASK) == CMD_GRP_F5_F8) begin
        nf[8:5] = cmd[3:0];
      end else if ((cmd & CMD_GRP4_MASK) == CMD_GRP_F9_F12) begin
        nf[12:9] = cmd[3:0];
      end else if (cmd == CMD_F13_F20) begin
        if (len >= 3) nf[20:13] = nxt;
      end else if (cmd == CMD_F21_F28) begin
        if (len >= 3) nf[28:21] = nxt;
      end
      r.changed = (nf != loco_functions) || (nd != loco_forward);
      loco_functions = nf;
      loco_forward = nd;
    end
    last_err_byte = err;
    r.function_bits = loco_functions;
    r.forward = loco_forward;
    return r;
  endfunction

  function automatic int draw_wait();
    if (!idle_on || $urandom_range(0, 2) == 0) return 0;
    return int'($urandom_range(0, 8));
  endfunction

  function automatic packet_t build_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                           int len);
    packet_t p;
    p.byte_zero = b0;
    p.byte_one = b1;
    p.byte_two = b2;
    p.byte_three = b3;
    p.byte_four = b4;
    p.byte_five = b5;
    p.packet_length = LEN_W'(len);
    return p;
  endfunction

  task automatic queue_packet(packet_t p, bit drain);
    backlog_entry_t e;
    e.pkt = p;
    e.drain = drain;
    packet_backlog.push_back(e);
  endtask

  // Random packet, mostly addressed to this decoder with a matching shape
  task automatic make_packet(output packet_t p, output bit twice);
    logic [7:0]        pk [6];
    int                pick, kind, sh, nat, len;
    logic [ADDR_W-1:0] target;
    logic [7:0]        cmd;
    for (int i = 0; i < 6; i++) pk[i] = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6) target = own_address;
    else if (pick < 8) target = {7'd0, consist_addr};
    else target = ADDR_W'($urandom_range(0, 16383));
    sh = (target > 14'd127 || $urandom_range(0, 3) == 0) ? 1 : 0;
    if (sh != 0) begin
      pk[0] = {1'b1, 1'($urandom), target[13:8]};
      pk[1] = target[7:0];
    end else begin
      pk[0] = {1'b0, target[6:0]};
    end
    twice = 1'b0;
    kind = $urandom_range(0, 9);
    case (kind)
      0: begin
        cmd = {1'b0, 7'($urandom)};
        nat = 2;
      end
      1: begin
        cmd = CMD_SPEED_128;
        nat = 3;
      end
      2: begin
        cmd = CMD_GRP_F0_F4 | 8'($urandom_range(0, 31));
        nat = 3;
      end
      3: begin
        cmd = CMD_GRP_F5_F8 | 8'($urandom_range(0, 15));
        nat = 3;
      end
      4: begin
        cmd = CMD_GRP_F9_F12 | 8'($urandom_range(0, 15));
        nat = 3;
      end
      5: begin
        cmd = CMD_F13_F20;
        nat = 4;
      end
      6: begin
        cmd = CMD_F21_F28;
        nat = 4;
      end
      7, 8: begin
        cmd = CMD_CV_WRITE | 8'($urandom_range(0, 3));
        if ($urandom_range(0, 7) == 0) begin
          pk[2 + sh] = CV_BYTE_RESET;
          pk[3 + sh] = CV_VALUE_RESET;
        end
        twice = ($urandom_range(0, 9) < 7);
        nat = 5;
      end
      default: begin
        cmd = 8'($urandom);
        nat = $urandom_range(2, 5);
      end
    endcase
    pk[1 + sh] = cmd;
    pick = $urandom_range(0, 19);
    if (pick < 14) len = (nat + sh > 6) ? 6 : nat + sh;
    else if (pick < 19) len = $urandom_range(2, 6);
    else len = $urandom_range(0, 7);
    p = build_packet(pk[0], pk[1], pk[2], pk[3], pk[4], pk[5], len);
  endtask

  task automatic run_random(int count, bit with_drain);
    packet_t p;
    bit      twice;
    for (int n = 0; n < count; n++) begin
      make_packet(p, twice);
      queue_packet(p, with_drain && (n == count / 2));
      if (twice) queue_packet(p, 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (packet_backlog.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    if (idx == CFG_DECODER_ADDR) own_address = data;
    else consist_addr = data[CADDR_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Packet driver
  always @(negedge clk) begin : packet_driver
    backlog_entry_t e;
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (packet_backlog.size() != 0 &&
                   !(packet_backlog[0].drain && expected_results.size() != 0)) begin
        e = packet_backlog.pop_front();
        in_byte_zero <= e.pkt.byte_zero;
        in_byte_one <= e.pkt.byte_one;
        in_byte_two <= e.pkt.byte_two;
        in_byte_three <= e.pkt.byte_three;
        in_byte_four <= e.pkt.byte_four;
        in_byte_five <= e.pkt.byte_five;
        in_packet_length <= e.pkt.packet_length;
        in_valid <= 1'b1;
        send_gap <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result stall driver
  always @(negedge clk) begin : result_stall
    int h;
    h = out_taken ? draw_wait() : recv_hold;
    if (h > 0) begin
      out_stall <= 1'b1;
      recv_hold <= h - 1;
    end else begin
      out_stall <= 1'b0;
      recv_hold <= 0;
    end
  end

  // Handshake monitor, checker and watchdog
  always @(posedge clk) begin : monitor
    bit      in_acc, out_acc;
    result_t want;
    in_acc = rst_n && in_valid && !in_stall;
    out_acc = rst_n && out_valid && !out_stall;
    in_taken <= in_acc;
    out_taken <= out_acc;
    if (in_acc)
      expected_results.push_back(decode_packet(build_packet(in_byte_zero, in_byte_one,
        in_byte_two, in_byte_three, in_byte_four, in_byte_five, int'(in_packet_length))));
    if (out_acc) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual functions 0x%0h", $time,
                 out_function_bits);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("function_bits", want.function_bits, out_function_bits);
        check_field("forward", want.forward, out_forward);
        check_field("changed", want.changed, out_changed);
        check_field("cv_write_request", want.cv_write_request, out_cv_write_request);
        check_field("cv_number", want.cv_number, out_cv_number);
        check_field("cv_value", want.cv_value, out_cv_value);
        check_field("reset_request", want.reset_request, out_reset_request);
      end
    end
    if (in_acc || out_acc) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("dcc_function_packet_decoder_core_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    logic [ADDR_W-1:0]  dec_set  [5];
    logic [CADDR_W-1:0] cons_set [5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_zero = '0;
    in_byte_one = '0;
    in_byte_two = '0;
    in_byte_three = '0;
    in_byte_four = '0;
    in_byte_five = '0;
    in_packet_length = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    send_gap = 0;
    recv_hold = 0;
    fail_count = 0;
    quiet_cycles = 0;
    idle_on = 1'b1;
    loco_functions = '0;
    loco_forward = 1'b1;
    last_err_byte = '0;
    own_address = DECODER_ADDR_RST;
    consist_addr = CONSIST_ADDR_RST;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed packets at the reset addresses (decoder 3, consist 0)
    queue_packet(build_packet(8'h03, CMD_GRP_F0_F4 | 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    queue_packet(build_packet(8'h03, CMD_GRP_F5_F8 | 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    queue_packet(build_packet(8'h03, CMD_GRP_F9_F12 | 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    queue_packet(build_packet(8'h03, CMD_F13_F20, 8'hFF, 8'h11, 8'h00, 8'h00, 4), 0);
    queue_packet(build_packet(8'h03, CMD_F21_F28, 8'hFF, 8'h22, 8'h00, 8'h00, 4), 0);
    // extended group too short to apply
    queue_packet(build_packet(8'h03, CMD_F13_F20, 8'h00, 8'h00, 8'h00, 8'h00, 2), 0);
    queue_packet(build_packet(8'h03, SPEED_BASIC, 8'h00, 8'h00, 8'h00, 8'h00, 2), 0);
    queue_packet(build_packet(8'h03, CMD_SPEED_128, 8'h80, 8'h00, 8'h00, 8'h00, 3), 0);
    // 128-step speed with a length off by one: direction kept
    queue_packet(build_packet(8'h03, CMD_SPEED_128, 8'h00, 8'h00, 8'h00, 8'h00, 4), 0);
    queue_packet(build_packet(8'h03, SPEED_BASIC | SPEED_DIR_FWD, 8'h00, 8'h00, 8'h00,
                              8'h00, 3), 0);
    queue_packet(build_packet(8'h00, CMD_GRP_F0_F4, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    queue_packet(build_packet(8'hC0, 8'h03, CMD_GRP_F5_F8, 8'h00, 8'h00, 8'h00, 4), 0);
    queue_packet(build_packet(8'h80, 8'h03, CMD_SPEED_128, 8'h00, 8'h00, 8'h00, 4), 0);
    // other address, and a command that fits no group
    queue_packet(build_packet(8'h05, CMD_GRP_F0_F4 | 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    queue_packet(build_packet(8'h03, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 3), 0);
    // CV writes each sent twice, highest CV, and decoder reset
    repeat (2) queue_packet(build_packet(8'h03, CMD_CV_WRITE, 8'h10, 8'h55, 8'hA5, 8'h00, 5), 0);
    repeat (2) queue_packet(build_packet(8'h03, CMD_CV_WRITE | 8'h03, 8'hFF, 8'h00, 8'h5A,
                                         8'h00, 5), 0);
    repeat (2) queue_packet(build_packet(8'h03, CMD_CV_WRITE, CV_BYTE_RESET, CV_VALUE_RESET,
                                         8'h3C, 8'h00, 5), 0);
    queue_packet(build_packet(8'h00, CMD_CV_WRITE, 8'h01, 8'h02, 8'h03, 8'h00, 5), 0);
    // lengths outside the packet range: error byte saturates
    queue_packet(build_packet(8'h03, CMD_GRP_F0_F4, 8'h00, 8'h00, 8'h00, 8'h00, 0), 0);
    queue_packet(build_packet(8'h03, CMD_GRP_F9_F12, 8'h00, 8'h00, 8'h00, 8'h00, 1), 0);
    queue_packet(build_packet(8'h03, CMD_GRP_F0_F4 | 8'h10, 8'h00, 8'h00, 8'h00, 8'h77, 7), 0);
    queue_packet(build_packet(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6), 0);
    queue_packet(build_packet(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 2), 0);
    wait_idle();

    // Random traffic over several address settings, extremes first
    dec_set[0] = '0;
    cons_set[0] = 7'd127;
    dec_set[1] = 14'd16383;
    cons_set[1] = '0;
    dec_set[2] = 14'd127;
    cons_set[2] = 7'd5;
    dec_set[3] = ADDR_W'($urandom_range(128, 16383));
    cons_set[3] = CADDR_W'($urandom_range(0, 127));
    dec_set[4] = ADDR_W'($urandom_range(0, 127));
    cons_set[4] = CADDR_W'($urandom_range(0, 127));
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_DECODER_ADDR, dec_set[s]);
      write_reg(CFG_CONSIST_ADDR, CFG_DATA_W'(cons_set[s]));
      idle_on = (s != 3);
      run_random(RANDOM_PER_SET, s == 2);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("dcc_function_packet_decoder_core_test OK");
    end else begin
      $display("dcc_function_packet_decoder_core_test NOT OK");
    end
    $finish;
  end

endmodule
